// ===== rtl/tcew_pkg.sv =====
package tcew_pkg;

   // Result command codes
   localparam logic [2:0] CMD_GLYPH  = 3'd0;
   localparam logic [2:0] CMD_FILL   = 3'd1;
   localparam logic [2:0] CMD_SCROLL = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_BEEP   = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] REG_GLYPH_WIDTH   = 3'd0;
   localparam logic [2:0] REG_LINE_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd2;
   localparam logic [2:0] REG_LINES_IN_VIEW = 3'd3;
   localparam logic [2:0] REG_TAB_WIDTH     = 3'd4;
   localparam logic [2:0] REG_BG_COLOR      = 3'd5;

   // Configuration reset values
   localparam logic [6:0]  RST_GLYPH_WIDTH   = 7'd8;
   localparam logic [6:0]  RST_LINE_HEIGHT   = 7'd16;
   localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd320;
   localparam logic [7:0]  RST_LINES_IN_VIEW = 8'd20;
   localparam logic [7:0]  RST_TAB_WIDTH     = 8'd32;
   localparam logic [3:0]  RST_BG_COLOR      = 4'd15;

   // Parser phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ESC     = 3'd1;
   localparam logic [2:0] PH_BRACKET = 3'd2;
   localparam logic [2:0] PH_ONE     = 3'd3;
   localparam logic [2:0] PH_TWO     = 3'd4;

   // Byte codes
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_BEL     = 8'h07;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_FF      = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_K       = 8'h4B;
   localparam logic [7:0] CH_M       = 8'h6D;

   // Attribute numbers after ESC [
   localparam logic [6:0] SGR_RESET         = 7'd0;
   localparam logic [6:0] SGR_BOLD          = 7'd1;
   localparam logic [6:0] SGR_UNDERLINE     = 7'd4;
   localparam logic [6:0] SGR_REVERSE       = 7'd7;
   localparam logic [6:0] SGR_BOLD_OFF      = 7'd21;
   localparam logic [6:0] SGR_UNDERLINE_OFF = 7'd24;
   localparam logic [6:0] SGR_REVERSE_OFF   = 7'd27;
   localparam logic [6:0] SGR_FG_FIRST      = 7'd30;
   localparam logic [6:0] SGR_FG_LAST       = 7'd37;

   // One result beat
   typedef struct packed {
      logic [2:0]  command;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [11:0] span_width;
      logic [7:0]  glyph;
      logic [3:0]  fg_color;
      logic [3:0]  bg_color;
      logic        bold;
      logic        underline;
      logic        reverse;
      logic        last;
   } rsp_type;

endpackage

// ===== rtl/tcew_rem.sv =====
// Iterative remainder unit: one dividend bit per cycle, restoring form.
module tcew_rem #(
   parameter int XW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [XW-1:0] dividend,
   input  logic [7:0]    divisor,
   output logic          done,
   output logic [7:0]    remainder
);

   localparam int CNT_W = $clog2(XW + 1);

   logic [XW-1:0]    quo_ff, quo_in;
   logic [8:0]       rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [8:0]       rem_shift;

   // Shift one dividend bit in, subtract when it fits
   always_comb begin
      rem_shift = {rem_ff[7:0], quo_ff[XW-1]};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = 9'd0;
         cnt_in = CNT_W'(XW);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[XW-2:0], 1'b0};
         rem_in = (rem_shift >= {1'b0, divisor}) ? rem_shift - {1'b0, divisor} : rem_shift;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[7:0];

endmodule

// ===== rtl/tcew_rsp.sv =====
// Result output register: holds one beat until the consumer takes it.
module tcew_rsp (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  tcew_pkg::rsp_type load_data,
   output logic             free,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output tcew_pkg::rsp_type rsp_data
);

   logic              valid_ff, valid_in;
   tcew_pkg::rsp_type data_ff, data_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/text_console_escape_writer_core.sv =====
// Text console writer: takes one text byte per req beat and produces up to two
// draw commands (glyph, fill span, scroll, clear, beep) on the rsp channel,
// tracking a pixel cursor, bold/underline/reverse and the foreground color and
// parsing ESC [ n K / ESC [ n m. One byte is handled at a time; req_ready is
// high only while the sequencer is idle. Each byte passes S_DECODE; a glyph then
// passes S_GLYPH, and every result waits in S_EMIT until the rsp register is free.
// A tab runs the remainder unit one bit per cycle. The rsp output register
// lets the next byte be taken while the last result still waits.
module text_console_escape_writer_core #(
   parameter int COORD_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_command,
   output logic [11:0] rsp_pos_x,
   output logic [11:0] rsp_pos_y,
   output logic [11:0] rsp_span_width,
   output logic [7:0]  rsp_glyph,
   output logic [3:0]  rsp_fg_color,
   output logic [3:0]  rsp_bg_color,
   output logic        rsp_bold,
   output logic        rsp_underline,
   output logic        rsp_reverse,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int CW = COORD_BITS;
   localparam int WW = ((CW > 14) ? CW : 14) + 1;
   localparam int XW = CW + 1;
   localparam logic [WW-1:0] CMAX_W = WW'((1 << CW) - 1);
   localparam logic [CW-1:0] CMAX   = CW'((1 << CW) - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_TAB    = 3'd2;
   localparam logic [2:0] S_GLYPH  = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   // Configuration
   logic [6:0]  glyph_width_ff, glyph_width_in;
   logic [6:0]  line_height_ff, line_height_in;
   logic [11:0] screen_width_ff, screen_width_in;
   logic [7:0]  lines_in_view_ff, lines_in_view_in;
   logic [7:0]  tab_width_ff, tab_width_in;
   logic [3:0]  bg_color_ff, bg_color_in;
   logic [CW-1:0] bottom_ff, bottom_in;

   // Console state
   logic [2:0]    state_ff, state_in;
   logic [2:0]    ret_ff, ret_in;
   logic [CW-1:0] cursor_x_ff, cursor_x_in;
   logic [CW-1:0] cursor_y_ff, cursor_y_in;
   logic [2:0]    phase_ff, phase_in;
   logic [6:0]    num_ff, num_in;
   logic          bold_ff, bold_in;
   logic          underline_ff, underline_in;
   logic          reverse_ff, reverse_in;
   logic [3:0]    fg_ff, fg_in;
   logic [7:0]    char_ff, char_in;
   tcew_pkg::rsp_type pend_ff, pend_in;

   // Working values
   logic [14:0]   bottom_prod;
   logic [7:0]    rows;
   logic          dec_char;
   logic [6:0]    digit;
   logic          normal;
   logic          final_b;
   logic [2:0]    fg_sel;
   logic [7:0]    tab_div;
   logic [WW-1:0] tab_x;
   logic [WW-1:0] tab_up;
   logic [WW-1:0] glyph_end;
   logic [WW-1:0] y_next;
   logic          wrap;
   logic          at_bottom;
   logic [WW-1:0] span_diff;
   tcew_pkg::rsp_type base;

   logic          rem_start;
   logic          rem_done;
   logic [7:0]    rem_val;
   logic          out_free;
   logic          out_load;
   tcew_pkg::rsp_type out_data;

   function automatic logic [CW-1:0] sat(input logic [WW-1:0] v);
      sat = (v > CMAX_W) ? CMAX : CW'(v);
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // Configuration writes and the bottom row
   always_comb begin
      glyph_width_in   = glyph_width_ff;
      line_height_in   = line_height_ff;
      screen_width_in  = screen_width_ff;
      lines_in_view_in = lines_in_view_ff;
      tab_width_in     = tab_width_ff;
      bg_color_in      = bg_color_ff;
      if (csr_valid) begin
         case (csr_index)
            tcew_pkg::REG_GLYPH_WIDTH:   glyph_width_in   = csr_wdata[6:0];
            tcew_pkg::REG_LINE_HEIGHT:   line_height_in   = csr_wdata[6:0];
            tcew_pkg::REG_SCREEN_WIDTH:  screen_width_in  = csr_wdata;
            tcew_pkg::REG_LINES_IN_VIEW: lines_in_view_in = csr_wdata[7:0];
            tcew_pkg::REG_TAB_WIDTH:     tab_width_in     = csr_wdata[7:0];
            tcew_pkg::REG_BG_COLOR:      bg_color_in      = csr_wdata[3:0];
            default: ;
         endcase
      end
      rows        = (lines_in_view_ff == 8'd0) ? 8'd0 : lines_in_view_ff - 8'd1;
      bottom_prod = 15'(rows) * 15'(line_height_ff);
      bottom_in   = sat(WW'(bottom_prod));
   end

   // Shared arithmetic operands
   always_comb begin
      dec_char  = (char_ff inside {[tcew_pkg::CH_ZERO:tcew_pkg::CH_NINE]});
      digit     = 7'(char_ff - tcew_pkg::CH_ZERO);
      tab_div   = (tab_width_ff == 8'd0) ? 8'd1 : tab_width_ff;
      tab_x     = WW'(cursor_x_ff) + WW'(1);
      tab_up    = (rem_val == 8'd0) ? tab_x : tab_x + WW'(tab_div) - WW'(rem_val);
      glyph_end = WW'(cursor_x_ff) + WW'(glyph_width_ff);
      wrap      = (glyph_end >= WW'(screen_width_ff));
      y_next    = WW'(cursor_y_ff) + WW'(line_height_ff);
      at_bottom = !(cursor_y_ff < bottom_ff);
      span_diff = (WW'(screen_width_ff) > WW'(cursor_x_ff)) ?
                  WW'(screen_width_ff) - WW'(cursor_x_ff) : '0;
      fg_sel    = 3'(num_ff - tcew_pkg::SGR_FG_FIRST);

      base            = '0;
      base.fg_color   = fg_ff;
      base.bg_color   = bg_color_ff;
      base.bold       = bold_ff;
      base.underline  = underline_ff;
      base.reverse    = reverse_ff;
      base.last       = 1'b1;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      phase_in     = phase_ff;
      num_in       = num_ff;
      bold_in      = bold_ff;
      underline_in = underline_ff;
      reverse_in   = reverse_ff;
      fg_in        = fg_ff;
      char_in      = char_ff;
      pend_in      = pend_ff;
      rem_start    = 1'b0;
      out_load     = 1'b0;
      normal       = 1'b0;
      final_b      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               char_in  = req_char_code;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_IDLE;
            ret_in   = S_IDLE;
            // escape parser
            case (phase_ff)
               tcew_pkg::PH_ESC: begin
                  phase_in = tcew_pkg::PH_IDLE;
                  if (char_ff == tcew_pkg::CH_BRACKET) begin
                     phase_in = tcew_pkg::PH_BRACKET;
                     num_in   = 7'd0;
                  end else begin
                     normal = 1'b1;
                  end
               end
               tcew_pkg::PH_BRACKET: begin
                  if (dec_char) begin
                     num_in   = digit;
                     phase_in = tcew_pkg::PH_ONE;
                  end else begin
                     final_b = 1'b1;
                  end
               end
               tcew_pkg::PH_ONE: begin
                  if (dec_char) begin
                     num_in   = 7'({num_ff, 3'b000} + {num_ff, 1'b0}) + digit;
                     phase_in = tcew_pkg::PH_TWO;
                  end else begin
                     final_b = 1'b1;
                  end
               end
               tcew_pkg::PH_TWO: final_b = 1'b1;
               default: begin
                  phase_in = tcew_pkg::PH_IDLE;
                  normal   = 1'b1;
               end
            endcase

            // final byte of an escape
            if (final_b) begin
               phase_in = tcew_pkg::PH_IDLE;
               num_in   = 7'd0;
               if (char_ff == tcew_pkg::CH_K) begin
                  pend_in            = base;
                  pend_in.command    = tcew_pkg::CMD_FILL;
                  pend_in.pos_x      = 12'(cursor_x_ff);
                  pend_in.pos_y      = 12'(cursor_y_ff);
                  pend_in.span_width = 12'(CW'(span_diff));
                  state_in           = S_EMIT;
               end else if (char_ff == tcew_pkg::CH_M) begin
                  case (num_ff)
                     tcew_pkg::SGR_RESET: begin
                        bold_in      = 1'b0;
                        underline_in = 1'b0;
                        reverse_in   = 1'b0;
                        fg_in        = 4'd0;
                     end
                     tcew_pkg::SGR_BOLD:          bold_in      = 1'b1;
                     tcew_pkg::SGR_UNDERLINE:     underline_in = 1'b1;
                     tcew_pkg::SGR_REVERSE:       reverse_in   = 1'b1;
                     tcew_pkg::SGR_BOLD_OFF:      bold_in      = 1'b0;
                     tcew_pkg::SGR_UNDERLINE_OFF: underline_in = 1'b0;
                     tcew_pkg::SGR_REVERSE_OFF:   reverse_in   = 1'b0;
                     default: begin
                        // color numbers map to bit-reversed palette index
                        if (num_ff inside {[tcew_pkg::SGR_FG_FIRST:tcew_pkg::SGR_FG_LAST]}) begin
                           fg_in = {1'b0, fg_sel[0], fg_sel[1], fg_sel[2]};
                        end
                     end
                  endcase
               end
            end

            // plain byte
            if (normal) begin
               case (char_ff)
                  tcew_pkg::CH_NUL: ;
                  tcew_pkg::CH_BEL: begin
                     pend_in         = base;
                     pend_in.command = tcew_pkg::CMD_BEEP;
                     state_in        = S_EMIT;
                  end
                  tcew_pkg::CH_TAB: begin
                     rem_start = 1'b1;
                     state_in  = S_TAB;
                  end
                  tcew_pkg::CH_FF: begin
                     cursor_x_in     = '0;
                     cursor_y_in     = '0;
                     pend_in         = base;
                     pend_in.command = tcew_pkg::CMD_CLEAR;
                     state_in        = S_EMIT;
                  end
                  tcew_pkg::CH_ESC: begin
                     phase_in = tcew_pkg::PH_ESC;
                     num_in   = 7'd0;
                  end
                  tcew_pkg::CH_LF: begin
                     cursor_x_in = '0;
                     if (!at_bottom) begin
                        cursor_y_in = sat(y_next);
                     end else begin
                        cursor_y_in     = bottom_ff;
                        pend_in         = base;
                        pend_in.command = tcew_pkg::CMD_SCROLL;
                        pend_in.pos_y   = 12'(bottom_ff);
                        state_in        = S_EMIT;
                     end
                  end
                  tcew_pkg::CH_CR: begin
                     cursor_x_in        = '0;
                     pend_in            = base;
                     pend_in.command    = tcew_pkg::CMD_FILL;
                     pend_in.pos_y      = 12'(cursor_y_ff);
                     pend_in.span_width = 12'(CW'(screen_width_ff));
                     state_in           = S_EMIT;
                  end
                  default: begin
                     state_in = S_GLYPH;
                     // wrap first when the cell would reach the edge
                     if (wrap) begin
                        cursor_x_in = '0;
                        if (!at_bottom) begin
                           cursor_y_in = sat(y_next);
                        end else begin
                           cursor_y_in     = bottom_ff;
                           pend_in         = base;
                           pend_in.command = tcew_pkg::CMD_SCROLL;
                           pend_in.pos_y   = 12'(bottom_ff);
                           pend_in.last    = 1'b0;
                           ret_in          = S_GLYPH;
                           state_in        = S_EMIT;
                        end
                     end
                  end
               endcase
            end
         end

         S_TAB: begin
            if (rem_done) begin
               cursor_x_in = sat(tab_up);
               state_in    = S_IDLE;
            end
         end

         S_GLYPH: begin
            pend_in         = base;
            pend_in.command = tcew_pkg::CMD_GLYPH;
            pend_in.pos_x   = 12'(cursor_x_ff);
            pend_in.pos_y   = 12'(cursor_y_ff);
            pend_in.glyph   = char_ff;
            cursor_x_in     = sat(glyph_end);
            ret_in          = S_IDLE;
            state_in        = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ret_ff;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_width_ff   <= tcew_pkg::RST_GLYPH_WIDTH;
         line_height_ff   <= tcew_pkg::RST_LINE_HEIGHT;
         screen_width_ff  <= tcew_pkg::RST_SCREEN_WIDTH;
         lines_in_view_ff <= tcew_pkg::RST_LINES_IN_VIEW;
         tab_width_ff     <= tcew_pkg::RST_TAB_WIDTH;
         bg_color_ff      <= tcew_pkg::RST_BG_COLOR;
         state_ff         <= S_IDLE;
         ret_ff           <= S_IDLE;
         cursor_x_ff      <= '0;
         cursor_y_ff      <= '0;
         phase_ff         <= tcew_pkg::PH_IDLE;
         num_ff           <= 7'd0;
         bold_ff          <= 1'b0;
         underline_ff     <= 1'b0;
         reverse_ff       <= 1'b0;
         fg_ff            <= 4'd0;
      end else begin
         glyph_width_ff   <= glyph_width_in;
         line_height_ff   <= line_height_in;
         screen_width_ff  <= screen_width_in;
         lines_in_view_ff <= lines_in_view_in;
         tab_width_ff     <= tab_width_in;
         bg_color_ff      <= bg_color_in;
         state_ff         <= state_in;
         ret_ff           <= ret_in;
         cursor_x_ff      <= cursor_x_in;
         cursor_y_ff      <= cursor_y_in;
         phase_ff         <= phase_in;
         num_ff           <= num_in;
         bold_ff          <= bold_in;
         underline_ff     <= underline_in;
         reverse_ff       <= reverse_in;
         fg_ff            <= fg_in;
      end
      bottom_ff <= bottom_in;
      char_ff   <= char_in;
      pend_ff   <= pend_in;
   end

   // Tab rounding: remainder of (cursor_x + 1) by the tab width
   tcew_rem #(
      .XW(XW)
   ) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (XW'(cursor_x_ff) + XW'(1)),
      .divisor   (tab_div),
      .done      (rem_done),
      .remainder (rem_val)
   );

   // Result register
   tcew_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .load_data (pend_ff),
      .free      (out_free),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (out_data)
   );

   assign rsp_command    = out_data.command;
   assign rsp_pos_x      = out_data.pos_x;
   assign rsp_pos_y      = out_data.pos_y;
   assign rsp_span_width = out_data.span_width;
   assign rsp_glyph      = out_data.glyph;
   assign rsp_fg_color   = out_data.fg_color;
   assign rsp_bg_color   = out_data.bg_color;
   assign rsp_bold       = out_data.bold;
   assign rsp_underline  = out_data.underline;
   assign rsp_reverse    = out_data.reverse;
   assign rsp_last       = out_data.last;

endmodule
